FILE: design/wnm_pkg.sv
`timescale 1ns / 1ps

package wnm_pkg;

   localparam int COUNT_WIDTH     = 16;
   localparam int CHAR_WIDTH      = 8;
   localparam int WEIGHT_WIDTH    = 12;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 12;
   localparam int WSUM_WIDTH      = 28;
   localparam int FRAC_BITS       = 8;
   localparam int WDIV_WIDTH      = WSUM_WIDTH - FRAC_BITS;
   localparam int ID_WIDTH        = 21;
   localparam int COMPARED_WIDTH  = 16;

   localparam logic [WEIGHT_WIDTH-1:0]   WEIGHT_RESET = 12'd256;
   localparam logic signed [ID_WIDTH-1:0] ID_MAX      = 21'sh0FFFFF;
   localparam logic signed [ID_WIDTH-1:0] ID_MIN      = 21'sh100000;
   localparam logic [COMPARED_WIDTH-1:0] COMPARED_MAX = 16'hFFFF;

   localparam logic [CHAR_WIDTH-1:0] CASE_BIT     = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_T = 8'h74;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_U = 8'h75;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_T = 8'h54;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_U = 8'h55;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_C = 8'h63;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_G = 8'h67;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_N = 8'h6E;
   localparam logic [CHAR_WIDTH-1:0] CHAR_GAP     = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE   = 8'h20;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_WEIGHT_AC,
      CSR_WEIGHT_AG,
      CSR_WEIGHT_AU,
      CSR_WEIGHT_CG,
      CSR_WEIGHT_CU,
      CSR_WEIGHT_GU,
      CSR_CASE_SENSITIVE,
      CSR_WEIGHTED_MODE
   } csr_index_type;

   typedef enum logic [1:0] {
      BASE_A,
      BASE_C,
      BASE_G,
      BASE_U
   } base_type;

   typedef struct packed {
      logic     valid;
      base_type code;
   } base_code_type;

   typedef struct packed {
      logic [WEIGHT_WIDTH-1:0] weight_ac;
      logic [WEIGHT_WIDTH-1:0] weight_ag;
      logic [WEIGHT_WIDTH-1:0] weight_au;
      logic [WEIGHT_WIDTH-1:0] weight_cg;
      logic [WEIGHT_WIDTH-1:0] weight_cu;
      logic [WEIGHT_WIDTH-1:0] weight_gu;
      logic                    case_sensitive;
      logic                    weighted_mode;
   } cfg_type;

   function automatic logic [CHAR_WIDTH-1:0] fold_char(input logic [CHAR_WIDTH-1:0] c,
                                                       input logic case_sensitive);
      logic [CHAR_WIDTH-1:0] f;
      f = case_sensitive ? c : (c | CASE_BIT);
      if (f == CHAR_LOWER_T) begin
         f = CHAR_LOWER_U;
      end else if (f == CHAR_UPPER_T) begin
         f = CHAR_UPPER_U;
      end
      return f;
   endfunction

   function automatic logic is_blank(input logic [CHAR_WIDTH-1:0] c);
      return (c == CHAR_GAP) || (c == CHAR_SPACE) || ((c | CASE_BIT) == CHAR_LOWER_N);
   endfunction

   function automatic base_code_type base_of(input logic [CHAR_WIDTH-1:0] c);
      base_code_type b;
      b.valid = 1'b1;
      b.code  = BASE_A;
      case (c)
         CHAR_LOWER_A: b.code = BASE_A;
         CHAR_LOWER_C: b.code = BASE_C;
         CHAR_LOWER_G: b.code = BASE_G;
         CHAR_LOWER_U: b.code = BASE_U;
         default:      b.valid = 1'b0;
      endcase
      return b;
   endfunction

   // weight is symmetric in the pair; equal or non-base codes add nothing
   function automatic logic [WEIGHT_WIDTH-1:0] pair_weight(input base_code_type p,
                                                           input base_code_type q,
                                                           input cfg_type cfg);
      logic [WEIGHT_WIDTH-1:0] w;
      w = '0;
      if (p.valid && q.valid) begin
         case ({p.code, q.code}) inside
            {BASE_A, BASE_C}, {BASE_C, BASE_A}: w = cfg.weight_ac;
            {BASE_A, BASE_G}, {BASE_G, BASE_A}: w = cfg.weight_ag;
            {BASE_A, BASE_U}, {BASE_U, BASE_A}: w = cfg.weight_au;
            {BASE_C, BASE_G}, {BASE_G, BASE_C}: w = cfg.weight_cg;
            {BASE_C, BASE_U}, {BASE_U, BASE_C}: w = cfg.weight_cu;
            {BASE_G, BASE_U}, {BASE_U, BASE_G}: w = cfg.weight_gu;
            default:                            w = '0;
         endcase
      end
      return w;
   endfunction

endpackage

FILE: design/wnm_if.sv
`timescale 1ns / 1ps

interface wnm_req_if;
   logic                              valid;
   logic                              ready;
   logic [wnm_pkg::CHAR_WIDTH-1:0]    char_first;
   logic [wnm_pkg::CHAR_WIDTH-1:0]    char_second;
   logic                              window_start;
   logic                              last_pair;

   modport source (output valid, output char_first, output char_second,
                   output window_start, output last_pair, input ready);
   modport sink   (input valid, input char_first, input char_second,
                   input window_start, input last_pair, output ready);
endinterface

interface wnm_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [wnm_pkg::ID_WIDTH-1:0]    identity_count;
   logic [wnm_pkg::COMPARED_WIDTH-1:0]     compared_count;

   modport source (output valid, output identity_count, output compared_count, input ready);
   modport sink   (input valid, input identity_count, input compared_count, output ready);
endinterface

FILE: design/wnm_csr.sv
`timescale 1ns / 1ps

module wnm_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [wnm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [wnm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output wnm_pkg::cfg_type                     cfg
);

   wnm_pkg::cfg_type cfg_ff;
   wnm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (wnm_pkg::csr_index_type'(csr_index))
            wnm_pkg::CSR_WEIGHT_AC:      cfg_in.weight_ac      = csr_wdata;
            wnm_pkg::CSR_WEIGHT_AG:      cfg_in.weight_ag      = csr_wdata;
            wnm_pkg::CSR_WEIGHT_AU:      cfg_in.weight_au      = csr_wdata;
            wnm_pkg::CSR_WEIGHT_CG:      cfg_in.weight_cg      = csr_wdata;
            wnm_pkg::CSR_WEIGHT_CU:      cfg_in.weight_cu      = csr_wdata;
            wnm_pkg::CSR_WEIGHT_GU:      cfg_in.weight_gu      = csr_wdata;
            wnm_pkg::CSR_CASE_SENSITIVE: cfg_in.case_sensitive = csr_wdata[0];
            wnm_pkg::CSR_WEIGHTED_MODE:  cfg_in.weighted_mode  = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.weight_ac      <= wnm_pkg::WEIGHT_RESET;
         cfg_ff.weight_ag      <= wnm_pkg::WEIGHT_RESET;
         cfg_ff.weight_au      <= wnm_pkg::WEIGHT_RESET;
         cfg_ff.weight_cg      <= wnm_pkg::WEIGHT_RESET;
         cfg_ff.weight_cu      <= wnm_pkg::WEIGHT_RESET;
         cfg_ff.weight_gu      <= wnm_pkg::WEIGHT_RESET;
         cfg_ff.case_sensitive <= 1'b0;
         cfg_ff.weighted_mode  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/wnm_accum.sv
`timescale 1ns / 1ps

module wnm_accum #(
   parameter int COUNT_WIDTH = wnm_pkg::COUNT_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  wnm_pkg::cfg_type                   cfg,
   wnm_req_if.sink                            req,
   output logic                               snap_valid,
   input  logic                               snap_ready,
   output logic [COUNT_WIDTH-1:0]             snap_match,
   output logic [COUNT_WIDTH-1:0]             snap_compared,
   output logic [wnm_pkg::WDIV_WIDTH-1:0]     snap_wdiv
);

   localparam int CW = wnm_pkg::CHAR_WIDTH;
   localparam int SW = wnm_pkg::WSUM_WIDTH;

   // input register
   logic          s1_valid_ff;
   logic [CW-1:0] char_first_ff;
   logic [CW-1:0] char_second_ff;
   logic          window_start_ff;
   logic          last_pair_ff;

   // running state
   logic                   match_mark_ff, match_mark_in;
   logic                   blank_mark_ff, blank_mark_in;
   logic [COUNT_WIDTH-1:0] match_total_ff, match_total_in;
   logic [COUNT_WIDTH-1:0] compared_total_ff, compared_total_in;
   logic [SW-1:0]          wsum_ff, wsum_in;

   // pending report
   logic                          snap_valid_ff;
   logic [COUNT_WIDTH-1:0]        snap_match_ff;
   logic [COUNT_WIDTH-1:0]        snap_compared_ff;
   logic [wnm_pkg::WDIV_WIDTH-1:0] snap_wdiv_ff;

   logic          s1_move;
   logic          snap_free;
   logic          req_ready;
   logic [CW-1:0] fx, fy;
   logic [wnm_pkg::WEIGHT_WIDTH-1:0] w;
   logic [SW:0]   wsum_add;

   assign snap_free = !snap_valid_ff || snap_ready;
   assign s1_move   = s1_valid_ff && (!last_pair_ff || snap_free);
   assign req_ready = !s1_valid_ff || s1_move;
   assign req.ready = req_ready;

   always_comb begin
      fx = wnm_pkg::fold_char(char_first_ff, cfg.case_sensitive);
      fy = wnm_pkg::fold_char(char_second_ff, cfg.case_sensitive);
      w  = wnm_pkg::pair_weight(wnm_pkg::base_of(fx), wnm_pkg::base_of(fy), cfg);

      match_mark_in = window_start_ff ? 1'b1 : match_mark_ff;
      blank_mark_in = window_start_ff ? 1'b1 : blank_mark_ff;
      wsum_in       = wsum_ff;
      wsum_add      = {1'b0, wsum_ff} + (SW+1)'(w);

      if (!wnm_pkg::is_blank(fx) && !wnm_pkg::is_blank(fy)) begin
         blank_mark_in = 1'b0;
         if (fx != fy) begin
            match_mark_in = 1'b0;
            wsum_in       = wsum_add[SW] ? {SW{1'b1}} : wsum_add[SW-1:0];
         end
      end

      // counting uses the marks as they stand after this position
      compared_total_in = compared_total_ff;
      match_total_in    = match_total_ff;
      if (!blank_mark_in) begin
         if (compared_total_ff != {COUNT_WIDTH{1'b1}}) begin
            compared_total_in = compared_total_ff + 1'b1;
         end
         if (match_mark_in && (match_total_ff != {COUNT_WIDTH{1'b1}})) begin
            match_total_in = match_total_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req.valid;
      end
      if (req_ready && req.valid) begin
         char_first_ff   <= req.char_first;
         char_second_ff  <= req.char_second;
         window_start_ff <= req.window_start;
         last_pair_ff    <= req.last_pair;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_mark_ff     <= 1'b1;
         blank_mark_ff     <= 1'b1;
         match_total_ff    <= '0;
         compared_total_ff <= '0;
         wsum_ff           <= '0;
      end else if (s1_move) begin
         if (last_pair_ff) begin
            match_mark_ff     <= 1'b1;
            blank_mark_ff     <= 1'b1;
            match_total_ff    <= '0;
            compared_total_ff <= '0;
            wsum_ff           <= '0;
         end else begin
            match_mark_ff     <= match_mark_in;
            blank_mark_ff     <= blank_mark_in;
            match_total_ff    <= match_total_in;
            compared_total_ff <= compared_total_in;
            wsum_ff           <= wsum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (s1_move && last_pair_ff) begin
         snap_valid_ff <= 1'b1;
      end else if (snap_ready) begin
         snap_valid_ff <= 1'b0;
      end
      if (s1_move && last_pair_ff) begin
         snap_match_ff    <= match_total_in;
         snap_compared_ff <= compared_total_in;
         snap_wdiv_ff     <= wsum_in[SW-1:wnm_pkg::FRAC_BITS];
      end
   end

   assign snap_valid    = snap_valid_ff;
   assign snap_match    = snap_match_ff;
   assign snap_compared = snap_compared_ff;
   assign snap_wdiv     = snap_wdiv_ff;

endmodule

FILE: design/wnm_report.sv
`timescale 1ns / 1ps

module wnm_report #(
   parameter int COUNT_WIDTH = wnm_pkg::COUNT_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  wnm_pkg::cfg_type                   cfg,
   input  logic                               snap_valid,
   output logic                               snap_ready,
   input  logic [COUNT_WIDTH-1:0]             snap_match,
   input  logic [COUNT_WIDTH-1:0]             snap_compared,
   input  logic [wnm_pkg::WDIV_WIDTH-1:0]     snap_wdiv,
   wnm_rsp_if.source                          rsp
);

   localparam int IW  = wnm_pkg::ID_WIDTH;
   localparam int DW  = ((COUNT_WIDTH > wnm_pkg::WDIV_WIDTH) ? COUNT_WIDTH
                                                             : wnm_pkg::WDIV_WIDTH) + 2;
   localparam int CXW = (COUNT_WIDTH > wnm_pkg::COMPARED_WIDTH) ? COUNT_WIDTH
                                                                : wnm_pkg::COMPARED_WIDTH;
   localparam logic signed [DW-1:0] ID_MAX_EXT = DW'(wnm_pkg::ID_MAX);
   localparam logic signed [DW-1:0] ID_MIN_EXT = DW'(wnm_pkg::ID_MIN);

   logic                                  rsp_valid_ff;
   logic signed [IW-1:0]                  identity_ff, identity_in;
   logic [wnm_pkg::COMPARED_WIDTH-1:0]    compared_ff, compared_in;
   logic signed [DW-1:0]                  id_wide;
   logic [CXW-1:0]                        cmp_wide;
   logic                                  load;

   assign snap_ready = !rsp_valid_ff || rsp.ready;
   assign load       = snap_valid && snap_ready;

   always_comb begin
      if (cfg.weighted_mode) begin
         id_wide = $signed(DW'(snap_compared)) - $signed(DW'(snap_wdiv));
      end else begin
         id_wide = $signed(DW'(snap_match));
      end
      if (id_wide > ID_MAX_EXT) begin
         identity_in = wnm_pkg::ID_MAX;
      end else if (id_wide < ID_MIN_EXT) begin
         identity_in = wnm_pkg::ID_MIN;
      end else begin
         identity_in = id_wide[IW-1:0];
      end

      cmp_wide = CXW'(snap_compared);
      if (cmp_wide > CXW'(wnm_pkg::COMPARED_MAX)) begin
         compared_in = wnm_pkg::COMPARED_MAX;
      end else begin
         compared_in = cmp_wide[wnm_pkg::COMPARED_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load) begin
         identity_ff <= identity_in;
         compared_ff <= compared_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.identity_count = identity_ff;
   assign rsp.compared_count = compared_ff;

endmodule

FILE: design/weighted_nucleotide_mismatch_counter_unit.sv
`timescale 1ns / 1ps
// A last_pair request passes from the input register through the report register (count
// update) to the output register (identity), where its response shows.
// Throughput: one request per cycle, but a stalled response lets two reports wait;
// a further last_pair request then holds in the input register and stops new requests.
// Reset (synchronous, active high) empties the pipeline, clears the counts and restores the
// register defaults.

module weighted_nucleotide_mismatch_counter_unit #(
   parameter int COUNT_WIDTH = wnm_pkg::COUNT_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [wnm_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [wnm_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   wnm_req_if.sink                              req_chan,
   wnm_rsp_if.source                            rsp_chan
);

   wnm_pkg::cfg_type               cfg;
   logic                           snap_valid;
   logic                           snap_ready;
   logic [COUNT_WIDTH-1:0]         snap_match;
   logic [COUNT_WIDTH-1:0]         snap_compared;
   logic [wnm_pkg::WDIV_WIDTH-1:0] snap_wdiv;

   wnm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wnm_accum #(.COUNT_WIDTH(COUNT_WIDTH)) u_accum (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req           (req_chan),
      .snap_valid    (snap_valid),
      .snap_ready    (snap_ready),
      .snap_match    (snap_match),
      .snap_compared (snap_compared),
      .snap_wdiv     (snap_wdiv)
   );

   wnm_report #(.COUNT_WIDTH(COUNT_WIDTH)) u_report (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .snap_valid    (snap_valid),
      .snap_ready    (snap_ready),
      .snap_match    (snap_match),
      .snap_compared (snap_compared),
      .snap_wdiv     (snap_wdiv),
      .rsp           (rsp_chan)
   );

endmodule

FILE: design/wnm_checker.sv
`timescale 1ns / 1ps

module wnm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic signed [wnm_pkg::ID_WIDTH-1:0]   rsp_identity_count,
   input logic [wnm_pkg::COMPARED_WIDTH-1:0]    rsp_compared_count
);

   // a response waits until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_identity_count) && $stable(rsp_compared_count))
      else $error("response payload changed while stalled");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   // identity never exceeds the compared count unless that count is clipped
   a_identity_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_compared_count != wnm_pkg::COMPARED_MAX) |->
         $signed({rsp_identity_count[wnm_pkg::ID_WIDTH-1], rsp_identity_count})
            <= $signed({6'b0, rsp_compared_count}))
      else $error("identity above compared count");

endmodule

bind weighted_nucleotide_mismatch_counter_unit wnm_checker u_wnm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_identity_count (rsp_chan.identity_count),
   .rsp_compared_count (rsp_chan.compared_count)
);

FILE: verif/weighted_nucleotide_mismatch_counter_unit_test.sv
`timescale 1ns / 1ps

module weighted_nucleotide_mismatch_counter_unit_test;
   import wnm_pkg::*;

   typedef enum logic {
      ROW_REQ,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      logic signed [ID_WIDTH-1:0] id;
      logic [COMPARED_WIDTH-1:0]  compared;
   } report_type;

   typedef struct {
      row_kind_type            kind;
      csr_index_type           csr;
      logic [CSR_DATA_WIDTH-1:0] value;
      logic [CHAR_WIDTH-1:0]   char_first;
      logic [CHAR_WIDTH-1:0]   char_second;
      logic                    window_start;
      logic                    last_pair;
      bit                      typed;
      report_type              want;
   } step_row_type;

   localparam logic [WSUM_WIDTH-1:0] WSUM_SAT = '1;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASES = 8;
   localparam int PHASE_REQUESTS = 115;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   wnm_req_if req_link ();
   wnm_rsp_if rsp_link ();

   weighted_nucleotide_mismatch_counter_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_link),
      .rsp_chan  (rsp_link)
   );

   // shadow of the block's registers and counters
   cfg_type                  shadow_cfg;
   bit                       all_match;
   bit                       all_blank;
   logic [COUNT_WIDTH-1:0]   match_total;
   logic [COUNT_WIDTH-1:0]   compared_total;
   logic [WSUM_WIDTH-1:0]    weight_total;

   report_type   expected_reports[$];
   step_row_type directed_rows[$];
   int        mismatches;
   int        burst_left;
   string     base_letters  = "acgtuACGTU";
   string     blank_letters = "- nN";

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("weighted_nucleotide_mismatch_counter_unit_test NOT OK");
      $finish;
   end

   function automatic logic [CHAR_WIDTH-1:0] canonical_char(input logic [CHAR_WIDTH-1:0] c);
      logic [CHAR_WIDTH-1:0] f;
      f = shadow_cfg.case_sensitive ? c : (c | 8'h20);
      if (f == "t") begin
         f = "u";
      end else if (f == "T") begin
         f = "U";
      end
      return f;
   endfunction

   function automatic bit blank_char(input logic [CHAR_WIDTH-1:0] c);
      return (c == "-") || (c == " ") || ((c | 8'h20) == "n");
   endfunction

   // ASCII order a < c < g < u, so sorting the pair gives one key per base pair
   function automatic logic [WEIGHT_WIDTH-1:0] substitution_weight(
      input logic [CHAR_WIDTH-1:0] x, input logic [CHAR_WIDTH-1:0] y);
      logic [CHAR_WIDTH-1:0] lo;
      logic [CHAR_WIDTH-1:0] hi;
      lo = (x < y) ? x : y;
      hi = (x < y) ? y : x;
      case ({lo, hi})
         "ac":    return shadow_cfg.weight_ac;
         "ag":    return shadow_cfg.weight_ag;
         "au":    return shadow_cfg.weight_au;
         "cg":    return shadow_cfg.weight_cg;
         "cu":    return shadow_cfg.weight_cu;
         "gu":    return shadow_cfg.weight_gu;
         default: return '0;
      endcase
   endfunction

   function automatic void clear_counts();
      all_match      = 1'b1;
      all_blank      = 1'b1;
      match_total    = '0;
      compared_total = '0;
      weight_total   = '0;
   endfunction

   function automatic bit count_pair(input logic [CHAR_WIDTH-1:0] a,
                                     input logic [CHAR_WIDTH-1:0] b,
                                     input logic window_start, input logic last_pair,
                                     output report_type rep);
      logic [CHAR_WIDTH-1:0] x;
      logic [CHAR_WIDTH-1:0] y;
      logic [WSUM_WIDTH:0]   sum;
      int                    idv;
      x = canonical_char(a);
      y = canonical_char(b);
      rep.id = '0;
      rep.compared = '0;
      if (window_start) begin
         all_match = 1'b1;
         all_blank = 1'b1;
      end
      if (!blank_char(x) && !blank_char(y)) begin
         all_blank = 1'b0;
         if (x != y) begin
            all_match = 1'b0;
            sum = {1'b0, weight_total} + (WSUM_WIDTH+1)'(substitution_weight(x, y));
            weight_total = sum[WSUM_WIDTH] ? WSUM_SAT : sum[WSUM_WIDTH-1:0];
         end
      end
      if (!all_blank) begin
         if (compared_total != '1) begin
            compared_total = compared_total + 1'b1;
         end
         if (all_match && match_total != '1) begin
            match_total = match_total + 1'b1;
         end
      end
      if (!last_pair) begin
         return 1'b0;
      end
      idv = shadow_cfg.weighted_mode ? int'(compared_total) : int'(match_total);
      if (shadow_cfg.weighted_mode) begin
         idv -= int'(weight_total[WSUM_WIDTH-1:FRAC_BITS]);
      end
      if (idv > ID_MAX) begin
         idv = int'(ID_MAX);
      end else if (idv < ID_MIN) begin
         idv = int'(ID_MIN);
      end
      rep.id = idv[ID_WIDTH-1:0];
      rep.compared = (compared_total > COMPARED_MAX) ? COMPARED_MAX : compared_total;
      clear_counts();
      return 1'b1;
   endfunction

   function automatic step_row_type req_row(input logic [CHAR_WIDTH-1:0] a,
                                            input logic [CHAR_WIDTH-1:0] b,
                                            input logic window_start, input logic last_pair,
                                            input bit typed = 1'b0, input int id = 0,
                                            input int compared = 0);
      step_row_type r;
      r.kind         = ROW_REQ;
      r.csr          = CSR_WEIGHT_AC;
      r.value        = '0;
      r.char_first   = a;
      r.char_second  = b;
      r.window_start = window_start;
      r.last_pair    = last_pair;
      r.typed        = typed;
      r.want.id      = ID_WIDTH'(id);
      r.want.compared = COMPARED_WIDTH'(compared);
      return r;
   endfunction

   function automatic step_row_type csr_row(input csr_index_type idx,
                                            input logic [CSR_DATA_WIDTH-1:0] value);
      step_row_type r;
      r = req_row(8'h00, 8'h00, 1'b0, 1'b0);
      r.kind  = ROW_CSR;
      r.csr   = idx;
      r.value = value;
      return r;
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] random_char();
      int r;
      r = $urandom_range(0, 15);
      if (r < 10) begin
         return base_letters[$urandom_range(0, 9)];
      end
      if (r < 12) begin
         return blank_letters[$urandom_range(0, 3)];
      end
      return CHAR_WIDTH'($urandom_range(0, 255));
   endfunction

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      case (idx)
         CSR_WEIGHT_AC:      shadow_cfg.weight_ac = value;
         CSR_WEIGHT_AG:      shadow_cfg.weight_ag = value;
         CSR_WEIGHT_AU:      shadow_cfg.weight_au = value;
         CSR_WEIGHT_CG:      shadow_cfg.weight_cg = value;
         CSR_WEIGHT_CU:      shadow_cfg.weight_cu = value;
         CSR_WEIGHT_GU:      shadow_cfg.weight_gu = value;
         CSR_CASE_SENSITIVE: shadow_cfg.case_sensitive = value[0];
         CSR_WEIGHTED_MODE:  shadow_cfg.weighted_mode = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // block is idle once all reports are in and the pipeline has flushed
   task automatic wait_idle();
      @(negedge clock);
      req_link.valid = 1'b0;
      while (expected_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_request(input logic [CHAR_WIDTH-1:0] a, input logic [CHAR_WIDTH-1:0] b,
                               input logic window_start, input logic last_pair,
                               input bit typed, input report_type typed_rep);
      int         gap;
      report_type rep;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_link.valid = 1'b0;
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                 : $urandom_range(1, 16);
      end
      burst_left--;
      @(negedge clock);
      req_link.valid        = 1'b1;
      req_link.char_first   = a;
      req_link.char_second  = b;
      req_link.window_start = window_start;
      req_link.last_pair    = last_pair;
      do @(posedge clock); while (req_link.ready !== 1'b1);
      if (count_pair(a, b, window_start, last_pair, rep)) begin
         expected_reports.push_back(typed ? typed_rep : rep);
      end
   endtask

   task automatic configure_phase(input int phase);
      logic [WEIGHT_WIDTH-1:0] w[6];
      bit                      cs;
      bit                      wm;
      foreach (w[i]) begin
         case (phase)
            1:       w[i] = '0;
            2:       w[i] = '1;
            4:       w[i] = WEIGHT_RESET;
            default: w[i] = WEIGHT_WIDTH'($urandom_range(0, 4095));
         endcase
      end
      case (phase)
         0:       begin cs = 1'b0; wm = 1'b0; end
         1, 2:    begin cs = 1'b0; wm = 1'b1; end
         3:       begin cs = 1'b1; wm = 1'b1; end
         4:       begin cs = 1'b1; wm = 1'b0; end
         default: begin
            cs = ($urandom_range(0, 1) != 0);
            wm = ($urandom_range(0, 1) != 0);
         end
      endcase
      wait_idle();
      write_csr(CSR_WEIGHT_AC, w[0]);
      write_csr(CSR_WEIGHT_AG, w[1]);
      write_csr(CSR_WEIGHT_AU, w[2]);
      write_csr(CSR_WEIGHT_CG, w[3]);
      write_csr(CSR_WEIGHT_CU, w[4]);
      write_csr(CSR_WEIGHT_GU, w[5]);
      write_csr(CSR_CASE_SENSITIVE, CSR_DATA_WIDTH'(cs));
      write_csr(CSR_WEIGHTED_MODE, CSR_DATA_WIDTH'(wm));
   endtask

   // mostly aligned sequences with many matches; some raw bytes and early ends
   task automatic run_sequences(input int requests);
      int                    sent;
      int                    len;
      logic [CHAR_WIDTH-1:0] a;
      logic [CHAR_WIDTH-1:0] b;
      logic                  ws;
      logic                  lp;
      report_type            none;
      sent = 0;
      none.id = '0;
      none.compared = '0;
      while (sent < requests) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            a = random_char();
            case ($urandom_range(0, 3))
               0, 1:    b = a;
               2:       b = a ^ CASE_BIT;
               default: b = random_char();
            endcase
            ws = (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 5) == 0);
            lp = (i == len - 1);
            if ($urandom_range(0, 23) == 0) begin
               a  = CHAR_WIDTH'($urandom_range(0, 255));
               b  = CHAR_WIDTH'($urandom_range(0, 255));
               ws = ($urandom_range(0, 1) != 0);
               lp = lp | ($urandom_range(0, 1) != 0);
            end
            send_request(a, b, ws, lp, 1'b0, none);
            sent++;
         end
      end
   endtask

   initial begin
      int tick;
      tick = 0;
      rsp_link.ready = 1'b0;
      forever begin
         @(negedge clock);
         case ((tick / 97) % 4)
            0:       rsp_link.ready = 1'b1;
            1:       rsp_link.ready = (tick % 3) != 0;
            2:       rsp_link.ready = ($urandom_range(0, 1) != 0);
            default: rsp_link.ready = ($urandom_range(0, 3) == 0);
         endcase
         tick++;
      end
   end

   always @(posedge clock) begin : check_reports
      report_type want;
      if (!reset && rsp_link.valid === 1'b1 && rsp_link.ready === 1'b1) begin
         if (expected_reports.size() == 0) begin
            if (mismatches < 10) begin
               $display("unexpected report: identity %0d compared %0d",
                        rsp_link.identity_count, rsp_link.compared_count);
            end
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_link.identity_count !== want.id ||
                rsp_link.compared_count !== want.compared) begin
               if (mismatches < 10) begin
                  $display("report mismatch: identity exp %0d got %0d, compared exp %0d got %0d",
                           want.id, rsp_link.identity_count,
                           want.compared, rsp_link.compared_count);
               end
               mismatches++;
            end
         end
      end
   end

   initial begin
      step_row_type row;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = CSR_WEIGHT_AC;
      csr_wdata             = '0;
      req_link.valid        = 1'b0;
      req_link.char_first   = '0;
      req_link.char_second  = '0;
      req_link.window_start = 1'b0;
      req_link.last_pair    = 1'b0;
      mismatches            = 0;
      burst_left            = 0;
      shadow_cfg.weight_ac  = WEIGHT_RESET;
      shadow_cfg.weight_ag  = WEIGHT_RESET;
      shadow_cfg.weight_au  = WEIGHT_RESET;
      shadow_cfg.weight_cg  = WEIGHT_RESET;
      shadow_cfg.weight_cu  = WEIGHT_RESET;
      shadow_cfg.weight_gu  = WEIGHT_RESET;
      shadow_cfg.case_sensitive = 1'b0;
      shadow_cfg.weighted_mode  = 1'b0;
      clear_counts();

      // register defaults: plain match counting, case folded
      directed_rows.push_back(req_row("a", "a", 1'b1, 1'b1, 1'b1, 1, 1));
      directed_rows.push_back(req_row(8'h00, 8'hFF, 1'b1, 1'b1, 1'b1, 0, 0));
      directed_rows.push_back(req_row("A", "a", 1'b1, 1'b1, 1'b1, 1, 1));
      directed_rows.push_back(req_row("T", "u", 1'b1, 1'b1, 1'b1, 1, 1));
      directed_rows.push_back(req_row("N", " ", 1'b1, 1'b1, 1'b1, 0, 0));
      // mismatch clears the match mark for the rest of the window
      directed_rows.push_back(req_row("g", "c", 1'b1, 1'b0));
      directed_rows.push_back(req_row("a", "a", 1'b0, 1'b1));
      // leading blank not counted, trailing blank counted as match
      directed_rows.push_back(req_row("-", "a", 1'b1, 1'b0));
      directed_rows.push_back(req_row("a", "a", 1'b0, 1'b0));
      directed_rows.push_back(req_row("n", "a", 1'b0, 1'b1));
      // non-base mismatch, then a new window restores the match mark
      directed_rows.push_back(req_row("a", "x", 1'b1, 1'b0));
      directed_rows.push_back(req_row("c", "c", 1'b1, 1'b1));
      // weighted identity goes negative with the largest weight
      directed_rows.push_back(csr_row(CSR_WEIGHTED_MODE, 12'd1));
      directed_rows.push_back(csr_row(CSR_WEIGHT_AC, 12'hFFF));
      directed_rows.push_back(req_row("a", "c", 1'b1, 1'b0));
      directed_rows.push_back(req_row("C", "A", 1'b0, 1'b1));
      directed_rows.push_back(csr_row(CSR_WEIGHT_GU, 12'd0));
      directed_rows.push_back(req_row("g", "t", 1'b1, 1'b1));
      // case sensitive: upper case bases mismatch lower case, carry no weight
      directed_rows.push_back(csr_row(CSR_CASE_SENSITIVE, 12'd1));
      directed_rows.push_back(req_row("A", "a", 1'b1, 1'b0));
      directed_rows.push_back(req_row("T", "U", 1'b0, 1'b0));
      directed_rows.push_back(req_row("a", "c", 1'b0, 1'b1));
      directed_rows.push_back(req_row("A", "C", 1'b1, 1'b1));
      directed_rows.push_back(req_row(8'hFF, 8'h00, 1'b1, 1'b1));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CSR) begin
            wait_idle();
            write_csr(row.csr, row.value);
         end else begin
            send_request(row.char_first, row.char_second, row.window_start, row.last_pair,
                         row.typed, row.want);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         configure_phase(p);
         run_sequences(PHASE_REQUESTS);
      end
      wait_idle();

      if (mismatches == 0) begin
         $display("weighted_nucleotide_mismatch_counter_unit_test OK");
      end else begin
         $display("weighted_nucleotide_mismatch_counter_unit_test NOT OK");
      end
      $finish;
   end

endmodule
